// File: hdl/jacobi_heat_grid_relaxation_macros.svh
// Assertion macros for the grid relaxation block and its checker.
// Needs a clock and an active-low reset passed in by the user.
`ifndef JACOBI_HEAT_GRID_RELAXATION_MACROS_SVH
`define JACOBI_HEAT_GRID_RELAXATION_MACROS_SVH

// Same-cycle implication.
`define JHG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define JHG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/jhg_pkg.sv
// Shared constants for the Jacobi grid relaxation block.
// No dependencies; used by the top level and the grid RAM instances.
`default_nettype none

package jhg_pkg;

	// Grid store dimensions; cell address is {row, col}, so MAX_COLS is a power of two.
	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int ADDR_W   = ROW_W + COL_W;
	localparam int DEPTH    = MAX_ROWS * MAX_COLS;

	localparam int CELL_W  = 16;
	localparam int SIZE_W  = 7;
	localparam int ROUND_W = 16;
	localparam int SUM_W   = CELL_W + 2;
	localparam int SIZE_MIN = 3;

	localparam logic [CELL_W-1:0] BORDER_TEMP = 16'hFF00;

	// APB register map
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_ROWS   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_COLS   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_ROUNDS = 2'd2;

	// Command codes on s_tuser
	localparam logic CMD_RUN  = 1'b0;
	localparam logic CMD_READ = 1'b1;

endpackage

`default_nettype wire

// File: hdl/jhg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module jhg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: hdl/jacobi_heat_grid_relaxation.sv
// Jacobi heat relaxation over a grid of up to 64 x 64 cells of unsigned 8.8 temperature.
// A run command (tuser 0) first writes the border to 255.0 and the interior to 0 in both
// grid buffers, one cell per cycle, then sweeps the interior once per round: one RAM read
// port fetches the four neighbours and the old center of each interior cell in turn, and
// one shared 18-bit adder accumulates them. The run stops early after a round that changes
// no cell; after its last write it enters the done state, which loads the result into the
// output register once that register is free. Buffers swap roles at each round end. A read
// command (tuser 1) inside the grid passes through a RAM read state, then the done state
// loads the output and raises m_tvalid; one outside the grid goes straight to the done
// state. One command is in flight at a time; s_tready is high only while idle, and a
// finished result waits in the output register.
// Depends on jhg_pkg and jhg_ram.
`default_nettype none

module jacobi_heat_grid_relaxation (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// APB configuration
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [jhg_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [jhg_pkg::PDATA_W-1:0]  pwdata,
	output logic      [jhg_pkg::PDATA_W-1:0]  prdata,
	output logic                              pready,
	// command stream
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [15:0]                  s_tdata,  // cell_row[5:0], cell_col[11:6], zero pad
	input  wire logic                         s_tuser,  // cmd
	// result stream
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic      [jhg_pkg::CELL_W-1:0]   m_tdata,  // cell_value
	output logic                              m_tuser   // out_of_range
);

	localparam int ROW_W  = jhg_pkg::ROW_W;
	localparam int COL_W  = jhg_pkg::COL_W;
	localparam int SIZE_W = jhg_pkg::SIZE_W;
	localparam int CELL_W = jhg_pkg::CELL_W;
	localparam int SUM_W  = jhg_pkg::SUM_W;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_INIT = 5'b00010,
		ST_CELL = 5'b00100,
		ST_RD   = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	// per-cell read sequence: north, south, west, east, center, then write
	typedef enum logic [5:0] {
		PH_N  = 6'b000001,
		PH_S  = 6'b000010,
		PH_W  = 6'b000100,
		PH_E  = 6'b001000,
		PH_C  = 6'b010000,
		PH_WR = 6'b100000
	} phase_t;

	state_t                     state_q;
	phase_t                     phase_q;
	logic [SIZE_W-1:0]          rows_q;
	logic [SIZE_W-1:0]          cols_q;
	logic [jhg_pkg::ROUND_W-1:0] rounds_q;
	logic [jhg_pkg::ROUND_W-1:0] left_q;
	logic [ROW_W-1:0]           r_q;
	logic [COL_W-1:0]           c_q;
	logic                       sel_q;
	logic                       changed_q;
	logic [SUM_W-1:0]           acc_q;
	logic [CELL_W-1:0]          res_value_q;
	logic                       res_oor_q;
	logic                       out_valid_q;
	logic [CELL_W-1:0]          out_value_q;
	logic                       out_oor_q;

	logic [SIZE_W-1:0]          nr;
	logic [SIZE_W-1:0]          nc;
	logic [ROW_W-1:0]           row_last;
	logic [COL_W-1:0]           col_last;
	logic [ROW_W-1:0]           row_pen;
	logic [COL_W-1:0]           col_pen;
	logic [ROW_W-1:0]           in_row;
	logic [COL_W-1:0]           in_col;
	logic                       in_oor;
	logic                       on_border;
	logic [1:0]                 ram_we;
	logic [jhg_pkg::ADDR_W-1:0] waddr;
	logic [jhg_pkg::ADDR_W-1:0] raddr;
	logic [CELL_W-1:0]          wdata;
	logic [CELL_W-1:0]          rdata0;
	logic [CELL_W-1:0]          rdata1;
	logic [CELL_W-1:0]          cur_rdata;
	logic [SUM_W-1:0]           acc_sum;
	logic [CELL_W-1:0]          mean;
	logic                       changed_now;
	logic                       cfg_wr;
	logic                       s_xfer;
	logic                       out_free;

	// sizes in use, clamped to 3..MAX
	always_comb begin
		if (rows_q < SIZE_W'(jhg_pkg::SIZE_MIN)) begin
			nr = SIZE_W'(jhg_pkg::SIZE_MIN);
		end else if (rows_q > SIZE_W'(jhg_pkg::MAX_ROWS)) begin
			nr = SIZE_W'(jhg_pkg::MAX_ROWS);
		end else begin
			nr = rows_q;
		end
		if (cols_q < SIZE_W'(jhg_pkg::SIZE_MIN)) begin
			nc = SIZE_W'(jhg_pkg::SIZE_MIN);
		end else if (cols_q > SIZE_W'(jhg_pkg::MAX_COLS)) begin
			nc = SIZE_W'(jhg_pkg::MAX_COLS);
		end else begin
			nc = cols_q;
		end
	end

	assign row_last = ROW_W'(nr - SIZE_W'(1));
	assign col_last = COL_W'(nc - SIZE_W'(1));
	assign row_pen  = ROW_W'(nr - SIZE_W'(2));
	assign col_pen  = COL_W'(nc - SIZE_W'(2));

	assign in_row = s_tdata[ROW_W-1:0];
	assign in_col = s_tdata[ROW_W +: COL_W];
	assign in_oor = ({1'b0, in_row} >= nr) || ({1'b0, in_col} >= nc);

	assign on_border = (r_q == '0) || (c_q == '0) || (r_q == row_last) || (c_q == col_last);

	assign cur_rdata   = sel_q ? rdata1 : rdata0;
	assign acc_sum     = ((phase_q == PH_S) ? SUM_W'(0) : acc_q) + SUM_W'(cur_rdata);
	assign mean        = acc_q[SUM_W-1:2];
	assign changed_now = changed_q || (mean != cur_rdata);

	assign s_tready = (state_q == ST_IDLE);
	assign s_xfer   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_value_q;
	assign m_tuser  = out_oor_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[3:2])
			jhg_pkg::REG_ROWS:   prdata = jhg_pkg::PDATA_W'(rows_q);
			jhg_pkg::REG_COLS:   prdata = jhg_pkg::PDATA_W'(cols_q);
			jhg_pkg::REG_ROUNDS: prdata = jhg_pkg::PDATA_W'(rounds_q);
			default:             prdata = '0;
		endcase
	end

	// RAM port steering
	always_comb begin
		ram_we = 2'b00;
		waddr  = {r_q, c_q};
		wdata  = mean;
		raddr  = {r_q, c_q};
		unique case (state_q)
			ST_IDLE: begin
				raddr = {in_row, in_col};
			end
			ST_INIT: begin
				// border and clear go to both buffers so border never needs rewriting
				ram_we = 2'b11;
				wdata  = on_border ? jhg_pkg::BORDER_TEMP : '0;
			end
			ST_CELL: begin
				unique case (phase_q)
					PH_N:    raddr = {r_q - ROW_W'(1), c_q};
					PH_S:    raddr = {r_q + ROW_W'(1), c_q};
					PH_W:    raddr = {r_q, c_q - COL_W'(1)};
					PH_E:    raddr = {r_q, c_q + COL_W'(1)};
					PH_C:    raddr = {r_q, c_q};
					PH_WR:   ram_we = sel_q ? 2'b01 : 2'b10;
					default: raddr = {r_q, c_q};
				endcase
			end
			default: begin
				raddr = {r_q, c_q};
			end
		endcase
	end

	jhg_ram #(
		.WIDTH(jhg_pkg::CELL_W),
		.DEPTH(jhg_pkg::DEPTH)
	) u_grid0 (
		.clk   (clk),
		.we    (ram_we[0]),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata0)
	);

	jhg_ram #(
		.WIDTH(jhg_pkg::CELL_W),
		.DEPTH(jhg_pkg::DEPTH)
	) u_grid1 (
		.clk   (clk),
		.we    (ram_we[1]),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata1)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_N;
			rows_q      <= SIZE_W'(jhg_pkg::MAX_ROWS);
			cols_q      <= SIZE_W'(jhg_pkg::MAX_COLS);
			rounds_q    <= jhg_pkg::ROUND_W'(1);
			left_q      <= '0;
			r_q         <= '0;
			c_q         <= '0;
			sel_q       <= 1'b0;
			changed_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[3:2])
					jhg_pkg::REG_ROWS:   rows_q   <= pwdata[SIZE_W-1:0];
					jhg_pkg::REG_COLS:   cols_q   <= pwdata[SIZE_W-1:0];
					jhg_pkg::REG_ROUNDS: rounds_q <= pwdata[jhg_pkg::ROUND_W-1:0];
					default: ;
				endcase
			end

			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_xfer) begin
						r_q <= '0;
						c_q <= '0;
						if (s_tuser == jhg_pkg::CMD_RUN) begin
							state_q <= ST_INIT;
						end else if (in_oor) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_DONE;
				end
				ST_INIT: begin
					if (c_q == col_last) begin
						if (r_q == row_last) begin
							if (rounds_q == '0) begin
								c_q     <= '0;
								state_q <= ST_DONE;
							end else begin
								r_q       <= ROW_W'(1);
								c_q       <= COL_W'(1);
								phase_q   <= PH_N;
								changed_q <= 1'b0;
								left_q    <= rounds_q;
								state_q   <= ST_CELL;
							end
						end else begin
							c_q <= '0;
							r_q <= r_q + ROW_W'(1);
						end
					end else begin
						c_q <= c_q + COL_W'(1);
					end
				end
				ST_CELL: begin
					unique case (phase_q)
						PH_N:    phase_q <= PH_S;
						PH_S:    phase_q <= PH_W;
						PH_W:    phase_q <= PH_E;
						PH_E:    phase_q <= PH_C;
						PH_C:    phase_q <= PH_WR;
						PH_WR: begin
							phase_q <= PH_N;
							if (c_q == col_pen) begin
								c_q <= COL_W'(1);
								if (r_q == row_pen) begin
									// round end: fresh buffer becomes current
									sel_q     <= !sel_q;
									r_q       <= ROW_W'(1);
									changed_q <= 1'b0;
									left_q    <= left_q - jhg_pkg::ROUND_W'(1);
									if (!changed_now || left_q == jhg_pkg::ROUND_W'(1)) begin
										state_q <= ST_DONE;
									end
								end else begin
									changed_q <= changed_now;
									r_q       <= r_q + ROW_W'(1);
								end
							end else begin
								changed_q <= changed_now;
								c_q       <= c_q + COL_W'(1);
							end
						end
						default: phase_q <= PH_N;
					endcase
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_CELL && (phase_q == PH_S || phase_q == PH_W ||
				phase_q == PH_E || phase_q == PH_C)) begin
			acc_q <= acc_sum;
		end
		if (s_xfer) begin
			res_value_q <= '0;
			res_oor_q   <= (s_tuser == jhg_pkg::CMD_READ) && in_oor;
		end
		if (state_q == ST_RD) begin
			res_value_q <= cur_rdata;
		end
		if (state_q == ST_DONE && out_free) begin
			out_value_q <= res_value_q;
			out_oor_q   <= res_oor_q;
		end
	end

endmodule

`default_nettype wire

// File: hdl/jhg_checker.sv
// Port-level checker for the grid relaxation block, bound to the top level.
// Depends on jacobi_heat_grid_relaxation_macros.svh.
`default_nettype none

`include "jacobi_heat_grid_relaxation_macros.svh"

module jhg_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata,
	input wire logic        m_tuser
);

	// a stalled result holds
	`JHG_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// out-of-range reads carry a zero value
	`JHG_ASSERT_NOW(a_oor_zero, clk, arst_n, m_tvalid && m_tuser, m_tdata == 16'h0000, "out-of-range result with nonzero value")

	// one command in flight: busy right after a transfer
	`JHG_ASSERT_NEXT(a_busy_after_xfer, clk, arst_n, s_tvalid && s_tready, !s_tready, "ready right after a command transfer")

endmodule

bind jacobi_heat_grid_relaxation jhg_checker u_jhg_checker (.*);

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking bench for jacobi_heat_grid_relaxation: APB register setup, command stream in,
// result stream out, with a grid predictor and result queue held in a small scoreboard class.
// Depends on jhg_pkg and the block's RTL only.
`default_nettype none

module tb_top;
	import jhg_pkg::*;

	typedef struct packed {
		logic [CELL_W-1:0] cell_value;
		logic              out_of_range;
	} grid_result_t;

	// Predicts results from the commands and compares them with what the block returns.
	class grid_scoreboard;
		logic [CELL_W-1:0]  cur_grid [DEPTH];
		logic [CELL_W-1:0]  nxt_grid [DEPTH];
		logic [SIZE_W-1:0]  rows_reg;
		logic [SIZE_W-1:0]  cols_reg;
		logic [ROUND_W-1:0] rounds_reg;
		grid_result_t       result_q[$];
		int                 errors;
		int                 n_checked;
		int                 n_runs;
		int                 n_reads;
		int                 n_outside;

		function new();
			foreach (cur_grid[i]) begin
				cur_grid[i] = '0;
				nxt_grid[i] = '0;
			end
			rows_reg   = 7'd64;
			cols_reg   = 7'd64;
			rounds_reg = 16'd1;
			errors     = 0;
			n_checked  = 0;
			n_runs     = 0;
			n_reads    = 0;
			n_outside  = 0;
		endfunction

		function void set_reg(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] val);
			case (idx)
				REG_ROWS:   rows_reg = val[SIZE_W-1:0];
				REG_COLS:   cols_reg = val[SIZE_W-1:0];
				REG_ROUNDS: rounds_reg = val[ROUND_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [PDATA_W-1:0] reg_value(logic [REG_IDX_W-1:0] idx);
			case (idx)
				REG_ROWS:   return PDATA_W'(rows_reg);
				REG_COLS:   return PDATA_W'(cols_reg);
				REG_ROUNDS: return PDATA_W'(rounds_reg);
				default:    return '0;
			endcase
		endfunction

		// sizes outside 3..MAX count as the nearest limit
		function int unsigned used_size(logic [SIZE_W-1:0] v, int unsigned top);
			if (v < SIZE_MIN)
				return SIZE_MIN;
			if (v > top)
				return top;
			return v;
		endfunction

		function int unsigned rows_used();
			return used_size(rows_reg, MAX_ROWS);
		endfunction

		function int unsigned cols_used();
			return used_size(cols_reg, MAX_COLS);
		endfunction

		function bit sweep_round(int unsigned nr, int unsigned nc);
			bit                moved;
			int unsigned       at;
			logic [SUM_W-1:0]  sum;
			moved = 1'b0;
			for (int unsigned r = 0; r < nr; r++) begin
				for (int unsigned c = 0; c < nc; c++) begin
					at = r * MAX_COLS + c;
					if (r == 0 || c == 0 || r == nr - 1 || c == nc - 1) begin
						nxt_grid[at] = BORDER_TEMP;
					end else begin
						sum = SUM_W'(cur_grid[at - MAX_COLS]) + SUM_W'(cur_grid[at + MAX_COLS])
							+ SUM_W'(cur_grid[at - 1]) + SUM_W'(cur_grid[at + 1]);
						nxt_grid[at] = sum[SUM_W-1:2];
					end
				end
			end
			for (int unsigned r = 0; r < nr; r++) begin
				for (int unsigned c = 0; c < nc; c++) begin
					at = r * MAX_COLS + c;
					if (cur_grid[at] != nxt_grid[at])
						moved = 1'b1;
					cur_grid[at] = nxt_grid[at];
				end
			end
			return moved;
		endfunction

		function void note_command(logic cmd, logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
			int unsigned  nr;
			int unsigned  nc;
			grid_result_t res;
			nr = rows_used();
			nc = cols_used();
			res = '0;
			if (cmd == CMD_RUN) begin
				n_runs++;
				for (int unsigned r = 0; r < nr; r++)
					for (int unsigned c = 0; c < nc; c++)
						cur_grid[r * MAX_COLS + c] =
							(r == 0 || c == 0 || r == nr - 1 || c == nc - 1) ? BORDER_TEMP : '0;
				// a round that changes nothing means the grid has settled
				for (int unsigned k = 0; k < rounds_reg; k++)
					if (!sweep_round(nr, nc))
						break;
			end else begin
				n_reads++;
				if (row >= nr || col >= nc) begin
					n_outside++;
					res.out_of_range = 1'b1;
				end else begin
					res.cell_value = cur_grid[row * MAX_COLS + col];
				end
			end
			result_q.push_back(res);
		endfunction

		function void check_result(logic [CELL_W-1:0] val, logic oor);
			grid_result_t want;
			if (result_q.size() == 0) begin
				$error("unexpected result: cell_value %h out_of_range %b", val, oor);
				errors++;
				return;
			end
			want = result_q.pop_front();
			n_checked++;
			if (val !== want.cell_value) begin
				$error("cell_value: expected %h, got %h", want.cell_value, val);
				errors++;
			end
			if (oor !== want.out_of_range) begin
				$error("out_of_range: expected %b, got %b", want.out_of_range, oor);
				errors++;
			end
		endfunction

		function int pending();
			return result_q.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [15:0]         s_tdata = '0;   // cell_row[5:0], cell_col[11:6], zero pad
	logic                s_tuser = 1'b0; // cmd
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [CELL_W-1:0]   m_tdata;        // cell_value
	logic                m_tuser;        // out_of_range

	int                  send_idle_pct = 0;
	int                  recv_idle_pct = 0;
	grid_scoreboard      sb;

	jacobi_heat_grid_relaxation u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	// result side: check every transfer, stall at random
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	initial begin
		#100000000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic send_cmd(logic cmd, logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {4'b0, col, row};
		do @(posedge clk); while (!s_tready);
		sb.note_command(cmd, row, col);
	endtask

	task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, val);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read_check(logic [REG_IDX_W-1:0] idx);
		logic [PDATA_W-1:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= PADDR_W'({idx, 2'b00});
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			got = prdata;
			@(posedge clk);
		end while (!pready);
		if (got !== sb.reg_value(idx)) begin
			$error("prdata: expected %h, got %h", sb.reg_value(idx), got);
			sb.errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// hold off until every result is back, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic configure(logic [SIZE_W-1:0] rows, logic [SIZE_W-1:0] cols,
			logic [ROUND_W-1:0] rounds);
		drain();
		apb_write(REG_ROWS, PDATA_W'(rows));
		apb_write(REG_COLS, PDATA_W'(cols));
		apb_write(REG_ROUNDS, PDATA_W'(rounds));
		apb_read_check(REG_ROWS);
		apb_read_check(REG_COLS);
		apb_read_check(REG_ROUNDS);
	endtask

	function automatic int unsigned near_limit(int unsigned n);
		case ($urandom_range(3))
			0:       return 0;
			1:       return n - 1;
			2:       return (n > 63) ? 63 : n;
			default: return 63;
		endcase
	endfunction

	task automatic random_read();
		int unsigned nr;
		int unsigned nc;
		int unsigned row;
		int unsigned col;
		int unsigned pick;
		nr = sb.rows_used();
		nc = sb.cols_used();
		pick = $urandom_range(19);
		if (pick < 12) begin
			row = $urandom_range(nr - 1);
			col = $urandom_range(nc - 1);
		end else if (pick < 17) begin
			row = $urandom_range(63);
			col = $urandom_range(63);
		end else begin
			row = near_limit(nr);
			col = near_limit(nc);
		end
		send_cmd(CMD_READ, ROW_W'(row), COL_W'(col));
	endtask

	function automatic logic [SIZE_W-1:0] pick_size();
		case ($urandom_range(9))
			0:       return SIZE_W'($urandom_range(2));
			1:       return SIZE_W'($urandom_range(127, 65));
			2:       return 7'd64;
			default: return SIZE_W'($urandom_range(8, 3));
		endcase
	endfunction

	task automatic random_phase(int n_items);
		logic [SIZE_W-1:0]  rows;
		logic [SIZE_W-1:0]  cols;
		logic [ROUND_W-1:0] rounds;
		int unsigned        nr;
		int unsigned        nc;
		int unsigned        cost;
		rows = pick_size();
		cols = pick_size();
		nr = sb.used_size(rows, MAX_ROWS);
		nc = sb.used_size(cols, MAX_COLS);
		// keep sweep time per run bounded; huge round counts only on tiny grids
		cost = 6 * (nr - 2) * (nc - 2);
		if (nr <= 5 && nc <= 5 && $urandom_range(3) == 0)
			rounds = 16'hFFFF;
		else if ($urandom_range(7) == 0)
			rounds = '0;
		else
			rounds = ROUND_W'($urandom_range(1 + 4000 / cost, 1));
		configure(rows, cols, rounds);
		send_cmd(CMD_RUN, '0, '0);
		for (int i = 1; i < n_items; i++) begin
			if ($urandom_range(99) < 5)
				send_cmd(CMD_RUN, ROW_W'($urandom), COL_W'($urandom));
			else
				random_read();
		end
	endtask

	initial begin
		sb = new();
		send_idle_pct = 24;
		recv_idle_pct = 73;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values, then a run on the full default grid
		apb_read_check(REG_ROWS);
		apb_read_check(REG_COLS);
		apb_read_check(REG_ROUNDS);
		send_cmd(CMD_RUN, '0, '0);
		send_cmd(CMD_READ, 6'd0, 6'd0);
		send_cmd(CMD_READ, 6'd63, 6'd63);
		send_cmd(CMD_READ, 6'd1, 6'd1);
		send_cmd(CMD_READ, 6'd1, 6'd2);
		send_cmd(CMD_READ, 6'd32, 6'd32);

		// smallest grid, zero rounds: cleared grid only
		configure(7'd3, 7'd3, 16'd0);
		send_cmd(CMD_RUN, '0, '0);
		send_cmd(CMD_READ, 6'd1, 6'd1);
		send_cmd(CMD_READ, 6'd2, 6'd2);
		send_cmd(CMD_READ, 6'd3, 6'd0);
		send_cmd(CMD_READ, 6'd0, 6'd3);
		send_cmd(CMD_READ, 6'd63, 6'd63);

		// clamped sizes, maximum rounds: runs until the grid settles
		configure(7'd0, 7'd127, 16'hFFFF);
		send_cmd(CMD_RUN, 6'd63, 6'd63);
		send_cmd(CMD_READ, 6'd1, 6'd30);
		send_cmd(CMD_READ, 6'd2, 6'd63);
		send_cmd(CMD_READ, 6'd3, 6'd5);

		configure(7'd64, 7'd5, 16'd3);
		send_cmd(CMD_RUN, '0, '0);
		send_cmd(CMD_READ, 6'd62, 6'd2);
		send_cmd(CMD_READ, 6'd63, 6'd4);
		send_cmd(CMD_READ, 6'd10, 6'd5);

		for (int stage = 0; stage < 3; stage++) begin
			case (stage)
				0: begin
					send_idle_pct = 24;
					recv_idle_pct = 73;
				end
				1: begin
					send_idle_pct = 73;
					recv_idle_pct = 24;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int p = 0; p < 12; p++)
				random_phase($urandom_range(50, 25));
		end

		s_tvalid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);

		$display("Covered %0d run commands and %0d reads (%0d outside the grid), %0d results checked.",
			sb.n_runs, sb.n_reads, sb.n_outside, sb.n_checked);
		$display("Grid sizes 3..64 incl. clamped values, round counts 0..65535, three stall mixes.");
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
